@@ rtl/ascon_pkg.sv @@
package ascon_pkg;

    typedef logic [63:0] word_t;
    typedef word_t [4:0] state_t;

    localparam word_t IV_WORD = 64'h80400c0600000000;
    localparam word_t PAD_TOP = 64'h8000000000000000;
    localparam word_t DSEP_BIT = 64'h0000000000000001;

    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_KEY_HIGH = 2'd0;
    localparam cfg_idx_t REG_KEY_LOW = 2'd1;

    localparam int DEFAULT_QUEUE_DEPTH = 2;

    localparam int RC_W = 4;
    localparam logic [RC_W-1:0] RC_FIRST_A = RC_W'(12 - 12);
    localparam logic [RC_W-1:0] RC_FIRST_B = RC_W'(12 - 6);
    localparam logic [RC_W-1:0] RC_LAST = RC_W'(11);

    localparam logic [3:0] FULL_BYTES = 4'd8;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_ASSOC = 2'd1,
        CMD_PLAIN = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ASSOC_EMPTY,
        PH_ASSOC_DATA,
        PH_PLAIN
    } phase_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_ASSOC,
        OP_PLAIN
    } op_kind_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RUN,
        B_EMIT
    } bstate_t;

    typedef struct packed {
        op_kind_t   kind;
        word_t      data;
        word_t      nonce_low;
        logic [3:0] count;
        logic       fin;
        logic       pad_block;
        logic       skip_absorb;
        logic       dsep_first;
    } op_t;

    typedef struct packed {
        word_t high;
        word_t low;
    } key_t;

    function automatic logic [7:0] round_const(input logic [RC_W-1:0] idx);
        logic [7:0] rc;
        case (idx)
            4'd0:    rc = 8'hf0;
            4'd1:    rc = 8'he1;
            4'd2:    rc = 8'hd2;
            4'd3:    rc = 8'hc3;
            4'd4:    rc = 8'hb4;
            4'd5:    rc = 8'ha5;
            4'd6:    rc = 8'h96;
            4'd7:    rc = 8'h87;
            4'd8:    rc = 8'h78;
            4'd9:    rc = 8'h69;
            4'd10:   rc = 8'h5a;
            4'd11:   rc = 8'h4b;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    function automatic word_t ror64(input word_t v, input int n);
        return (v >> n) | (v << (64 - n));
    endfunction

    function automatic state_t perm_round(input state_t s, input logic [7:0] rc);
        state_t x;
        state_t t;
        state_t r;
        x = s;
        x[2] = x[2] ^ {56'd0, rc};
        x[0] = x[0] ^ x[4];
        x[4] = x[4] ^ x[3];
        x[2] = x[2] ^ x[1];
        t[0] = x[0] ^ (~x[1] & x[2]);
        t[1] = x[1] ^ (~x[2] & x[3]);
        t[2] = x[2] ^ (~x[3] & x[4]);
        t[3] = x[3] ^ (~x[4] & x[0]);
        t[4] = x[4] ^ (~x[0] & x[1]);
        t[1] = t[1] ^ t[0];
        t[0] = t[0] ^ t[4];
        t[3] = t[3] ^ t[2];
        t[2] = ~t[2];
        r[0] = t[0] ^ ror64(t[0], 19) ^ ror64(t[0], 28);
        r[1] = t[1] ^ ror64(t[1], 61) ^ ror64(t[1], 39);
        r[2] = t[2] ^ ror64(t[2], 1) ^ ror64(t[2], 6);
        r[3] = t[3] ^ ror64(t[3], 10) ^ ror64(t[3], 17);
        r[4] = t[4] ^ ror64(t[4], 7) ^ ror64(t[4], 41);
        return r;
    endfunction

    // Ones over the first cnt bytes, counted from bit 63.
    function automatic word_t byte_mask(input logic [3:0] cnt);
        word_t m;
        for (int i = 0; i < 8; i++) begin
            m[63-8*i -: 8] = (4'(i) < cnt) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

    // Padding marker in the byte right after the last valid one.
    function automatic word_t pad_word(input logic [3:0] cnt);
        word_t p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            p[63-8*i] = (4'(i) == cnt);
        end
        return p;
    endfunction

endpackage

@@ rtl/ascon_if.sv @@
interface ascon_data_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [3:0]  byte_count;
    logic        final_block;

    modport source (
        output valid, cmd, block_high, block_low, byte_count, final_block,
        input  ready
    );
    modport sink (
        input  valid, cmd, block_high, block_low, byte_count, final_block,
        output ready
    );
endinterface

interface ascon_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_block;
    logic [3:0]  cipher_bytes;
    logic [63:0] tag_high;
    logic [63:0] tag_low;
    logic        tag_valid;

    modport source (
        output valid, cipher_block, cipher_bytes, tag_high, tag_low, tag_valid,
        input  ready
    );
    modport sink (
        input  valid, cipher_block, cipher_bytes, tag_high, tag_low, tag_valid,
        output ready
    );
endinterface

interface ascon_cfg_if import ascon_pkg::*; ();
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    word_t    wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface

@@ rtl/ascon_front.sv @@
module ascon_front import ascon_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    ascon_data_if.sink   data,
    input  logic         full,
    output logic         push,
    output op_t          op
);

    phase_t     phase_reg;
    phase_t     phase_next;
    logic       accept;
    logic       in_assoc;
    logic       in_text;
    logic [3:0] cnt_clamp;
    logic       fin;

    assign data.ready = !full;
    assign accept = data.valid && !full;
    assign fin = data.final_block;
    assign cnt_clamp = (data.byte_count > FULL_BYTES) ? FULL_BYTES : data.byte_count;
    assign in_assoc = phase_reg inside {PH_ASSOC_EMPTY, PH_ASSOC_DATA};
    assign in_text = phase_reg inside {PH_ASSOC_EMPTY, PH_PLAIN};

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (data.cmd)
                CMD_START: phase_next = PH_ASSOC_EMPTY;
                CMD_ASSOC:
                begin
                    if (in_assoc)
                    begin
                        phase_next = fin ? PH_PLAIN : PH_ASSOC_DATA;
                    end
                end
                CMD_PLAIN:
                begin
                    if (in_text)
                    begin
                        phase_next = fin ? PH_IDLE : PH_PLAIN;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    always_comb
    begin
        push = 1'b0;
        op.kind = OP_START;
        op.nonce_low = data.block_low;
        op.fin = fin;
        op.count = fin ? cnt_clamp : FULL_BYTES;
        op.pad_block = fin && (cnt_clamp == FULL_BYTES);
        op.skip_absorb = fin && (cnt_clamp == 4'd0) && (phase_reg == PH_ASSOC_EMPTY);
        op.dsep_first = (phase_reg == PH_ASSOC_EMPTY);
        // A short final block carries its own padding byte.
        if (fin && (cnt_clamp != FULL_BYTES))
        begin
            op.data = (data.block_high & byte_mask(cnt_clamp)) ^ pad_word(cnt_clamp);
        end
        else
        begin
            op.data = data.block_high;
        end
        case (data.cmd)
            CMD_START:
            begin
                // The nonce word is taken whole, whatever the count and final flag say.
                op.kind = OP_START;
                op.data = data.block_high;
                op.pad_block = 1'b0;
                push = accept;
            end
            CMD_ASSOC:
            begin
                op.kind = OP_ASSOC;
                push = accept && in_assoc;
            end
            CMD_PLAIN:
            begin
                op.kind = OP_PLAIN;
                push = accept && in_text;
            end
            default: push = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

@@ rtl/ascon_fifo.sv @@
module ascon_fifo import ascon_pkg::*; #(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  wr_op,
    output logic full,
    input  logic pop,
    output op_t  rd_op,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    op_t              mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign rd_op = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

@@ rtl/ascon_core.sv @@
module ascon_core import ascon_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  op_t         op,
    input  logic        empty,
    output logic        pop,
    input  key_t        key,
    ascon_res_if.source result
);

    bstate_t         state_reg;
    bstate_t         state_next;
    state_t          st_reg;
    state_t          st_next;
    logic [RC_W-1:0] rc_reg;
    logic [RC_W-1:0] rc_next;
    logic            second_reg;
    logic            second_next;
    op_t             cur_reg;
    op_t             cur_next;
    word_t           cipher_reg;
    word_t           cipher_next;

    word_t           pend_cipher_reg;
    word_t           pend_cipher_next;
    logic [3:0]      pend_bytes_reg;
    logic [3:0]      pend_bytes_next;
    word_t           pend_tag_high_reg;
    word_t           pend_tag_high_next;
    word_t           pend_tag_low_reg;
    word_t           pend_tag_low_next;
    logic            pend_tagv_reg;
    logic            pend_tagv_next;

    logic            out_valid_reg;
    logic            out_valid_next;
    word_t           out_cipher_reg;
    word_t           out_cipher_next;
    logic [3:0]      out_bytes_reg;
    logic [3:0]      out_bytes_next;
    word_t           out_tag_high_reg;
    word_t           out_tag_high_next;
    word_t           out_tag_low_reg;
    word_t           out_tag_low_next;
    logic            out_tagv_reg;
    logic            out_tagv_next;

    state_t          rnd;
    state_t          pre;
    logic [RC_W-1:0] pre_rc;
    logic            last;
    logic            need_second;
    logic            skip_now;
    logic            out_free;

    assign rnd = perm_round(st_reg, round_const(rc_reg));
    assign last = (rc_reg == RC_LAST);
    // A full final block is followed by a padding block of its own.
    assign need_second = !second_reg && cur_reg.pad_block && (cur_reg.kind != OP_START);
    assign skip_now = (op.kind == OP_ASSOC) && op.skip_absorb;
    assign out_free = !out_valid_reg || result.ready;

    assign result.valid = out_valid_reg;
    assign result.cipher_block = out_cipher_reg;
    assign result.cipher_bytes = out_bytes_reg;
    assign result.tag_high = out_tag_high_reg;
    assign result.tag_low = out_tag_low_reg;
    assign result.tag_valid = out_tagv_reg;

    // State words as they stand when the item's first round begins.
    always_comb
    begin
        pre = st_reg;
        pre_rc = RC_FIRST_B;
        case (op.kind)
            OP_START:
            begin
                pre[0] = IV_WORD;
                pre[1] = key.high;
                pre[2] = key.low;
                pre[3] = op.data;
                pre[4] = op.nonce_low;
                pre_rc = RC_FIRST_A;
            end
            OP_ASSOC:
            begin
                if (op.skip_absorb)
                begin
                    pre[4] = st_reg[4] ^ DSEP_BIT;
                end
                else
                begin
                    pre[0] = st_reg[0] ^ op.data;
                end
            end
            OP_PLAIN:
            begin
                pre[0] = st_reg[0] ^ op.data;
                if (op.dsep_first)
                begin
                    pre[4] = st_reg[4] ^ DSEP_BIT;
                end
                if (op.fin && !op.pad_block)
                begin
                    pre[1] = st_reg[1] ^ key.high;
                    pre[2] = st_reg[2] ^ key.low;
                    pre_rc = RC_FIRST_A;
                end
            end
            default: pre = st_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty && !skip_now)
                begin
                    state_next = B_RUN;
                end
            end
            B_RUN:
            begin
                if (last && !need_second)
                begin
                    state_next = (cur_reg.kind == OP_PLAIN) ? B_EMIT : B_IDLE;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        pop = 1'b0;
        st_next = st_reg;
        rc_next = rc_reg;
        second_next = second_reg;
        cur_next = cur_reg;
        cipher_next = cipher_reg;
        pend_cipher_next = pend_cipher_reg;
        pend_bytes_next = pend_bytes_reg;
        pend_tag_high_next = pend_tag_high_reg;
        pend_tag_low_next = pend_tag_low_reg;
        pend_tagv_next = pend_tagv_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_cipher_next = out_cipher_reg;
        out_bytes_next = out_bytes_reg;
        out_tag_high_next = out_tag_high_reg;
        out_tag_low_next = out_tag_low_reg;
        out_tagv_next = out_tagv_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    cur_next = op;
                    second_next = 1'b0;
                    st_next = pre;
                    rc_next = pre_rc;
                    cipher_next = (st_reg[0] ^ op.data) & byte_mask(op.count);
                end
            end
            B_RUN:
            begin
                if (!last)
                begin
                    st_next = rnd;
                    rc_next = rc_reg + 1'b1;
                end
                else if (need_second)
                begin
                    st_next = rnd;
                    st_next[0] = rnd[0] ^ PAD_TOP;
                    second_next = 1'b1;
                    rc_next = RC_FIRST_B;
                    if (cur_reg.kind == OP_PLAIN)
                    begin
                        st_next[1] = rnd[1] ^ key.high;
                        st_next[2] = rnd[2] ^ key.low;
                        rc_next = RC_FIRST_A;
                    end
                end
                else
                begin
                    st_next = rnd;
                    case (cur_reg.kind)
                        OP_START:
                        begin
                            st_next[3] = rnd[3] ^ key.high;
                            st_next[4] = rnd[4] ^ key.low;
                        end
                        OP_ASSOC:
                        begin
                            if (cur_reg.fin)
                            begin
                                st_next[4] = rnd[4] ^ DSEP_BIT;
                            end
                        end
                        OP_PLAIN:
                        begin
                            pend_cipher_next = cipher_reg;
                            pend_bytes_next = cur_reg.count;
                            pend_tagv_next = cur_reg.fin;
                            pend_tag_high_next = cur_reg.fin ? (rnd[3] ^ key.high) : '0;
                            pend_tag_low_next = cur_reg.fin ? (rnd[4] ^ key.low) : '0;
                        end
                        default: st_next = rnd;
                    endcase
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cipher_next = pend_cipher_reg;
                    out_bytes_next = pend_bytes_reg;
                    out_tag_high_next = pend_tag_high_reg;
                    out_tag_low_next = pend_tag_low_reg;
                    out_tagv_next = pend_tagv_reg;
                end
            end
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            rc_reg <= '0;
            second_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rc_reg <= rc_next;
            second_reg <= second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        cur_reg <= cur_next;
        cipher_reg <= cipher_next;
        pend_cipher_reg <= pend_cipher_next;
        pend_bytes_reg <= pend_bytes_next;
        pend_tag_high_reg <= pend_tag_high_next;
        pend_tag_low_reg <= pend_tag_low_next;
        pend_tagv_reg <= pend_tagv_next;
        out_cipher_reg <= out_cipher_next;
        out_bytes_reg <= out_bytes_next;
        out_tag_high_reg <= out_tag_high_next;
        out_tag_low_reg <= out_tag_low_next;
        out_tagv_reg <= out_tagv_next;
    end

endmodule

@@ rtl/ascon128_aead_encrypt_top.sv @@
// Ascon-128 encryption: one permutation round per cycle in the back engine.
// The engine takes one queued item at a time; a full final associated-data or
// plaintext block is followed by a second permutation for its padding block.
// A plaintext result goes to the pending registers, then waits in B_EMIT for a free output register.
// rst_n is asynchronous and active low; it clears the keys, the phase and the queue.
module ascon128_aead_encrypt_top import ascon_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    ascon_data_if.sink  data,
    ascon_res_if.source result,
    ascon_cfg_if.sink   cfg
);

    key_t key_reg;
    key_t key_next;
    logic push;
    logic pop;
    logic full;
    logic empty;
    op_t  wr_op;
    op_t  rd_op;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        key_next = key_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_KEY_HIGH: key_next.high = cfg.wdata;
                REG_KEY_LOW:  key_next.low = cfg.wdata;
                default:      key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    ascon_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .data  (data),
        .full  (full),
        .push  (push),
        .op    (wr_op)
    );

    ascon_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wr_op (wr_op),
        .full  (full),
        .pop   (pop),
        .rd_op (rd_op),
        .empty (empty)
    );

    ascon_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (rd_op),
        .empty  (empty),
        .pop    (pop),
        .key    (key_reg),
        .result (result)
    );

endmodule

@@ rtl/ascon_checker.sv @@
module ascon_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] cipher_block,
    input logic [3:0]  cipher_bytes,
    input logic [63:0] tag_high,
    input logic [63:0] tag_low,
    input logic        tag_valid
);

    logic       in_acc;
    logic       out_acc;
    logic [7:0] open_reg;
    logic [7:0] open_next;
    logic       sat_reg;
    logic       sat_next;

    assign in_acc = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // Items taken but not yet answered; once it saturates the count is not trusted.
    always_comb
    begin
        open_next = open_reg;
        sat_next = sat_reg;
        if (in_acc && !out_acc)
        begin
            if (open_reg == 8'hff)
            begin
                sat_next = 1'b1;
            end
            else
            begin
                open_next = open_reg + 1'b1;
            end
        end
        else if (out_acc && !in_acc && (open_reg != 8'h00))
        begin
            open_next = open_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            open_reg <= open_next;
            sat_reg <= sat_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cipher_block) && $stable(tag_valid))
        else $error("result item dropped or changed while stalled");

    a_no_tag_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !tag_valid |-> cipher_bytes == 4'd8 && tag_high == 64'd0
            && tag_low == 64'd0)
        else $error("non-final result carries tag data or a short count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cipher_bytes <= 4'd8)
        else $error("result byte count out of range");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && !sat_reg |-> open_reg != 8'h00)
        else $error("result item without a pending input item");

endmodule

bind ascon128_aead_encrypt_top ascon_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (data.valid),
    .in_ready     (data.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .cipher_block (result.cipher_block),
    .cipher_bytes (result.cipher_bytes),
    .tag_high     (result.tag_high),
    .tag_low      (result.tag_low),
    .tag_valid    (result.tag_valid)
);

@@ tb/sv/ascon128_aead_encrypt_top_tb.sv @@
module ascon128_aead_encrypt_top_tb;
    import ascon_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 80;
    localparam int RANDOM_ITEMS = 950;
    localparam int ITEMS_PER_KEY = 160;

    typedef enum logic [2:0] {
        KEEP_KEY,
        KEY_ZERO,
        KEY_ONES,
        KEY_RANDOM,
        KEY_SPLIT
    } key_pick_t;

    typedef struct packed {
        word_t      cipher;
        logic [3:0] nbytes;
        word_t      tag_hi;
        word_t      tag_lo;
        logic       tag_ok;
    } cipher_rec_t;

    typedef struct packed {
        cmd_t       cmd;
        word_t      hi;
        word_t      lo;
        logic [3:0] cnt;
        logic       fin;
        key_pick_t  key;
        logic       want_res;
        logic [3:0] want_bytes;
        logic       want_tag;
    } stim_row_t;

    logic clk;
    logic rst_n;

    ascon_data_if data_ch ();
    ascon_res_if  res_ch ();
    ascon_cfg_if  cfg_ch ();

    ascon128_aead_encrypt_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (data_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Shadow of the cipher state and key.
    word_t  sponge [5];
    phase_t msg_phase;
    word_t  key_hi;
    word_t  key_lo;

    cipher_rec_t pending_ciphertext [$];
    stim_row_t   directed_rows [$];

    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned results_checked;
    int unsigned items_taken;
    int unsigned random_effective;
    int unsigned msg_count;
    int unsigned stray_count;
    int unsigned key_sets;
    int          burst_left;
    bit          src_busy;

    function automatic word_t rot_r(input word_t v, input int n);
        return (v >> n) | (v << (64 - n));
    endfunction

    function automatic word_t lead_mask(input int n);
        if (n <= 0)
            return '0;
        if (n >= 8)
            return '1;
        return ~64'd0 << (64 - 8 * n);
    endfunction

    function automatic void permute_state(input int nr);
        word_t      x [5];
        word_t      t [5];
        logic [7:0] rc;
        for (int r = 12 - nr; r < 12; r++)
        begin
            // Round constants step down by 0x0f from 0xf0.
            rc = 8'hf0 - 8'(r * 15);
            x = sponge;
            x[2] = x[2] ^ {56'd0, rc};
            x[0] = x[0] ^ x[4];
            x[4] = x[4] ^ x[3];
            x[2] = x[2] ^ x[1];
            for (int i = 0; i < 5; i++)
            begin
                t[i] = x[i] ^ (~x[(i + 1) % 5] & x[(i + 2) % 5]);
            end
            t[1] = t[1] ^ t[0];
            t[0] = t[0] ^ t[4];
            t[3] = t[3] ^ t[2];
            t[2] = ~t[2];
            sponge[0] = t[0] ^ rot_r(t[0], 19) ^ rot_r(t[0], 28);
            sponge[1] = t[1] ^ rot_r(t[1], 61) ^ rot_r(t[1], 39);
            sponge[2] = t[2] ^ rot_r(t[2], 1) ^ rot_r(t[2], 6);
            sponge[3] = t[3] ^ rot_r(t[3], 10) ^ rot_r(t[3], 17);
            sponge[4] = t[4] ^ rot_r(t[4], 7) ^ rot_r(t[4], 41);
        end
    endfunction

    function automatic void encrypt_step(input cmd_t c, input word_t bh, input word_t bl,
                                         input logic [3:0] cnt_raw, input logic fin,
                                         output bit acted, output bit produced,
                                         output cipher_rec_t res);
        int    n;
        word_t keep;
        n = (cnt_raw > 4'd8) ? 8 : int'(cnt_raw);
        acted = 1'b0;
        produced = 1'b0;
        res = '0;
        case (c)
            CMD_START:
            begin
                sponge[0] = IV_WORD;
                sponge[1] = key_hi;
                sponge[2] = key_lo;
                sponge[3] = bh;
                sponge[4] = bl;
                permute_state(12);
                sponge[3] = sponge[3] ^ key_hi;
                sponge[4] = sponge[4] ^ key_lo;
                msg_phase = PH_ASSOC_EMPTY;
                acted = 1'b1;
            end
            CMD_ASSOC:
            begin
                if (msg_phase == PH_ASSOC_EMPTY || msg_phase == PH_ASSOC_DATA)
                begin
                    acted = 1'b1;
                    if (!fin)
                    begin
                        sponge[0] = sponge[0] ^ bh;
                        permute_state(6);
                        msg_phase = PH_ASSOC_DATA;
                    end
                    else
                    begin
                        if (n == 8)
                        begin
                            sponge[0] = sponge[0] ^ bh;
                            permute_state(6);
                            sponge[0] = sponge[0] ^ PAD_TOP;
                            permute_state(6);
                        end
                        else if (n > 0 || msg_phase == PH_ASSOC_DATA)
                        begin
                            sponge[0] = sponge[0] ^ (bh & lead_mask(n)) ^ (PAD_TOP >> (8 * n));
                            permute_state(6);
                        end
                        sponge[4] = sponge[4] ^ 64'd1;
                        msg_phase = PH_PLAIN;
                    end
                end
            end
            CMD_PLAIN:
            begin
                // Text straight after the start means there is no associated data.
                if (msg_phase == PH_ASSOC_EMPTY)
                begin
                    sponge[4] = sponge[4] ^ 64'd1;
                    msg_phase = PH_PLAIN;
                end
                if (msg_phase == PH_PLAIN)
                begin
                    acted = 1'b1;
                    produced = 1'b1;
                    if (!fin)
                    begin
                        sponge[0] = sponge[0] ^ bh;
                        res.cipher = sponge[0];
                        res.nbytes = 4'd8;
                        permute_state(6);
                    end
                    else
                    begin
                        if (n == 8)
                        begin
                            sponge[0] = sponge[0] ^ bh;
                            keep = sponge[0];
                            permute_state(6);
                            sponge[0] = sponge[0] ^ PAD_TOP;
                        end
                        else
                        begin
                            sponge[0] = sponge[0] ^ (bh & lead_mask(n)) ^ (PAD_TOP >> (8 * n));
                            keep = sponge[0] & lead_mask(n);
                        end
                        sponge[1] = sponge[1] ^ key_hi;
                        sponge[2] = sponge[2] ^ key_lo;
                        permute_state(12);
                        res.cipher = keep;
                        res.nbytes = 4'(n);
                        res.tag_hi = sponge[3] ^ key_hi;
                        res.tag_lo = sponge[4] ^ key_lo;
                        res.tag_ok = 1'b1;
                        msg_phase = PH_IDLE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic word_t rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [3:0] rand_nibble();
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic one_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // Count for a closing block: mostly legal, sometimes oversized.
    function automatic logic [3:0] tail_count();
        if ($urandom_range(0, 7) == 0)
            return 4'($urandom_range(9, 15));
        return 4'($urandom_range(0, 8));
    endfunction

    function automatic void add_row(input cmd_t c, input word_t h, input word_t l,
                                    input logic [3:0] n, input logic f, input key_pick_t k,
                                    input logic wr, input logic [3:0] wb, input logic wt);
        directed_rows.push_back('{c, h, l, n, f, k, wr, wb, wt});
    endfunction

    task automatic offer_item(input cmd_t c, input word_t bh, input word_t bl,
                              input logic [3:0] cnt, input logic fin,
                              output bit acted, output bit produced, output cipher_rec_t res);
        data_ch.valid <= 1'b1;
        data_ch.cmd <= c;
        data_ch.block_high <= bh;
        data_ch.block_low <= bl;
        data_ch.byte_count <= cnt;
        data_ch.final_block <= fin;
        src_busy = 1'b1;
        @(posedge clk);
        while (!data_ch.ready)
            @(posedge clk);
        encrypt_step(c, bh, bl, cnt, fin, acted, produced, res);
        if (produced)
            pending_ciphertext.push_back(res);
        items_taken++;
    endtask

    // The sender works in bursts; valid drops between bursts.
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            data_ch.valid <= 1'b0;
            src_busy = 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic issue(input cmd_t c, input word_t bh, input word_t bl,
                         input logic [3:0] cnt, input logic fin);
        bit          acted;
        bit          produced;
        cipher_rec_t res;
        offer_item(c, bh, bl, cnt, fin, acted, produced, res);
        pace_sender();
        if (acted)
            random_effective++;
    endtask

    task automatic wait_idle();
        if (src_busy)
        begin
            data_ch.valid <= 1'b0;
            src_busy = 1'b0;
        end
        while (pending_ciphertext.size() != 0)
            @(posedge clk);
        // Start and associated-data items leave no result behind to wait for.
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input word_t v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= v;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == REG_KEY_HIGH)
            key_hi = v;
        else
            key_lo = v;
    endtask

    task automatic load_key(input key_pick_t k);
        word_t h;
        word_t l;
        case (k)
            KEY_ZERO:
            begin
                h = '0;
                l = '0;
            end
            KEY_ONES:
            begin
                h = '1;
                l = '1;
            end
            KEY_SPLIT:
            begin
                h = '1;
                l = '0;
            end
            default:
            begin
                h = {$urandom, $urandom};
                l = {$urandom, $urandom};
            end
        endcase
        write_reg(REG_KEY_HIGH, h);
        write_reg(REG_KEY_LOW, l);
        cfg_ch.valid <= 1'b0;
        key_sets++;
    endtask

    task automatic run_message();
        int ad_mode;
        int nblk;
        msg_count++;
        issue(CMD_START, rand_word(), rand_word(), rand_nibble(), one_bit());
        if ($urandom_range(0, 24) == 0)
            return;
        ad_mode = $urandom_range(0, 3);
        if (ad_mode == 1)
            issue(CMD_ASSOC, rand_word(), rand_word(), 4'd0, 1'b1);
        else if (ad_mode >= 2)
        begin
            nblk = $urandom_range(0, 3);
            repeat (nblk)
                issue(CMD_ASSOC, rand_word(), rand_word(), rand_nibble(), 1'b0);
            if ($urandom_range(0, 24) == 0)
                return;
            issue(CMD_ASSOC, rand_word(), rand_word(), tail_count(), 1'b1);
        end
        nblk = $urandom_range(0, 4);
        repeat (nblk)
            issue(CMD_PLAIN, rand_word(), rand_word(), rand_nibble(), 1'b0);
        if ($urandom_range(0, 24) == 0)
            return;
        issue(CMD_PLAIN, rand_word(), rand_word(), tail_count(), 1'b1);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stall pattern: cycles through always ready, random, periodic and sparse.
    initial
    begin
        int unsigned stall_cycle;
        stall_cycle = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            case ((stall_cycle / 97) % 4)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 2) != 0);
                2: res_ch.ready <= (stall_cycle % 5 == 0);
                default: res_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
            stall_cycle++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("%0t: timed out after %0d cycles", $time, cycle_count);
            $display("ascon128_aead_encrypt_top verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        cipher_rec_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_ciphertext.size() == 0)
            begin
                $display("%0t: result with nothing expected, got cipher %h bytes %0d",
                         $time, res_ch.cipher_block, res_ch.cipher_bytes);
                fail_count++;
            end
            else
            begin
                want = pending_ciphertext.pop_front();
                results_checked++;
                if (res_ch.cipher_block !== want.cipher)
                begin
                    $display("%0t: cipher_block expected %h got %h",
                             $time, want.cipher, res_ch.cipher_block);
                    fail_count++;
                end
                if (res_ch.cipher_bytes !== want.nbytes)
                begin
                    $display("%0t: cipher_bytes expected %0d got %0d",
                             $time, want.nbytes, res_ch.cipher_bytes);
                    fail_count++;
                end
                if (res_ch.tag_valid !== want.tag_ok)
                begin
                    $display("%0t: tag_valid expected %b got %b",
                             $time, want.tag_ok, res_ch.tag_valid);
                    fail_count++;
                end
                if (res_ch.tag_high !== want.tag_hi)
                begin
                    $display("%0t: tag_high expected %h got %h",
                             $time, want.tag_hi, res_ch.tag_high);
                    fail_count++;
                end
                if (res_ch.tag_low !== want.tag_lo)
                begin
                    $display("%0t: tag_low expected %h got %h",
                             $time, want.tag_lo, res_ch.tag_low);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        bit          acted;
        bit          produced;
        cipher_rec_t res;
        int          key_round;
        int unsigned next_rekey;

        fail_count = 0;
        cycle_count = 0;
        results_checked = 0;
        items_taken = 0;
        random_effective = 0;
        msg_count = 0;
        stray_count = 0;
        key_sets = 0;
        burst_left = 0;
        src_busy = 1'b0;
        key_round = 0;

        for (int i = 0; i < 5; i++)
            sponge[i] = '0;
        msg_phase = PH_IDLE;
        key_hi = '0;
        key_lo = '0;

        rst_n = 1'b0;
        data_ch.valid = 1'b0;
        data_ch.cmd = CMD_START;
        data_ch.block_high = '0;
        data_ch.block_low = '0;
        data_ch.byte_count = '0;
        data_ch.final_block = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_KEY_HIGH;
        cfg_ch.wdata = '0;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Out-of-order items right after reset, then messages covering each corner.
        add_row(CMD_PLAIN, '1, '1, 4'd8, 1'b1, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_ASSOC, '1, '0, 4'd8, 1'b0, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_UNUSED, '1, '1, 4'd15, 1'b1, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_START, '0, '0, 4'd0, 1'b0, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_ASSOC, '1, '1, 4'd0, 1'b1, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_PLAIN, '0, '0, 4'd0, 1'b1, KEEP_KEY, 1'b1, 4'd0, 1'b1);
        add_row(CMD_START, '1, '1, 4'd15, 1'b1, KEY_ONES, 1'b0, 4'd0, 1'b0);
        add_row(CMD_PLAIN, '1, '0, 4'd3, 1'b0, KEEP_KEY, 1'b1, 4'd8, 1'b0);
        add_row(CMD_ASSOC, rand_word(), '0, 4'd4, 1'b1, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_PLAIN, '1, '1, 4'd8, 1'b1, KEEP_KEY, 1'b1, 4'd8, 1'b1);
        add_row(CMD_START, rand_word(), rand_word(), 4'd0, 1'b0, KEY_RANDOM, 1'b0, 4'd0, 1'b0);
        add_row(CMD_ASSOC, '1, '1, 4'd0, 1'b0, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_PLAIN, rand_word(), '0, 4'd8, 1'b1, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_UNUSED, '0, '0, 4'd0, 1'b0, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_ASSOC, rand_word(), '0, 4'd8, 1'b1, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        // Key changes between the associated data and the text of one message.
        add_row(CMD_PLAIN, rand_word(), '1, 4'd15, 1'b1, KEY_RANDOM, 1'b1, 4'd8, 1'b1);
        add_row(CMD_START, rand_word(), rand_word(), 4'd7, 1'b1, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_ASSOC, rand_word(), '0, 4'd9, 1'b0, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_ASSOC, '1, '0, 4'd0, 1'b1, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_PLAIN, rand_word(), '0, 4'd0, 1'b0, KEEP_KEY, 1'b1, 4'd8, 1'b0);
        add_row(CMD_PLAIN, '1, '1, 4'd5, 1'b1, KEEP_KEY, 1'b1, 4'd5, 1'b1);
        add_row(CMD_START, rand_word(), rand_word(), 4'd0, 1'b0, KEY_ZERO, 1'b0, 4'd0, 1'b0);
        add_row(CMD_ASSOC, rand_word(), '0, 4'd3, 1'b1, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_START, '1, '0, 4'd0, 1'b0, KEEP_KEY, 1'b0, 4'd0, 1'b0);
        add_row(CMD_PLAIN, '1, '0, 4'd1, 1'b1, KEEP_KEY, 1'b1, 4'd1, 1'b1);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].key != KEEP_KEY)
            begin
                wait_idle();
                load_key(directed_rows[i].key);
            end
            offer_item(directed_rows[i].cmd, directed_rows[i].hi, directed_rows[i].lo,
                       directed_rows[i].cnt, directed_rows[i].fin, acted, produced, res);
            pace_sender();
            if (produced !== directed_rows[i].want_res
                || (produced && (res.nbytes !== directed_rows[i].want_bytes
                                 || res.tag_ok !== directed_rows[i].want_tag)))
            begin
                $display("%0t: directed item %0d expected result %b bytes %0d tag %b, got %b %0d %b",
                         $time, i, directed_rows[i].want_res, directed_rows[i].want_bytes,
                         directed_rows[i].want_tag, produced, res.nbytes, res.tag_ok);
                fail_count++;
            end
        end

        next_rekey = 0;
        while (random_effective < RANDOM_ITEMS)
        begin
            if (random_effective >= next_rekey)
            begin
                wait_idle();
                case (key_round % 5)
                    0: load_key(KEY_RANDOM);
                    1: load_key(KEY_SPLIT);
                    2: load_key(KEY_ZERO);
                    3: load_key(KEY_ONES);
                    default: load_key(KEY_RANDOM);
                endcase
                key_round++;
                next_rekey += ITEMS_PER_KEY;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                stray_count++;
                issue(cmd_t'($urandom_range(0, 3)), rand_word(), rand_word(),
                      rand_nibble(), one_bit());
            end
            else
                run_message();
        end

        wait_idle();

        $display("Run covered %0d messages, %0d stray items and %0d key settings.",
                 msg_count, stray_count, key_sets);
        $display("%0d items taken, %0d ciphertext results compared, %0d mismatches.",
                 items_taken, results_checked, fail_count);
        if (fail_count == 0 && pending_ciphertext.size() == 0)
            $display("ascon128_aead_encrypt_top verification clean");
        else
            $display("ascon128_aead_encrypt_top verification failed");
        $finish;
    end

endmodule
